FILE: rtl/dssi_pkg.sv
`default_nettype none

package dssi_pkg;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SCALE = 1'b0;

    // Parser limits.
    localparam logic [4:0] MAX_FRAC_DIGITS = 5'd18;

    // Character codes the parser recognizes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Largest magnitudes that still fit in int32.
    localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ADD,
        ST_CLOSE,
        ST_NEG,
        ST_DIV,
        ST_ROUND,
        ST_FIX,
        ST_SIGN,
        ST_EMIT
    } dssi_state_t;

    // Power of ten for a fraction digit count of 0 to 18.
    function automatic logic [63:0] pow10(input logic [4:0] k);
        logic [63:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/decimal_string_to_scaled_int_unit.sv
// Channel  | Direction | Signals                                  | Request
// ---------+-----------+------------------------------------------+-------------------------
// input    | in        | in_valid, in_ready, character, last      | one byte of the string
// output   | out       | out_valid, out_ready, value, ok          | one parse result
// config   | in        | psel, penable, pwrite, paddr, pwdata,    | scale_factor at addr 0
//          |           | prdata, pready                           |
//
// A byte is decoded in a prepare step, and a digit adds an accumulate step (acc*10 and the sum
// through the shared adder). A byte with last set adds a close step; a good parse then runs the
// negate, restoring division, rounding, fix and sign steps, skipping division and rounding when
// there are no fraction digits, and an emit step hands off the result, all through the one 69-bit adder.
// in_ready is high only while the sequencer is idle. Reset (rst_n low, asynchronous) clears the
// parse state and sets scale_factor to 1. A result held by out_ready low stalls the hand-off of
// the next closing byte, and no request is accepted until the result register frees up.
`default_nettype none

module decimal_string_to_scaled_int_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dssi_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dssi_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dssi_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    // Input channel.
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    character,
    input  wire logic                          last,
    // Output channel.
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 value,
    output logic                               ok
);
    import dssi_pkg::*;

    dssi_state_t        state_reg, state_next;
    logic signed [31:0] scale_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               started_reg, started_next;
    logic               sep_reg, sep_next;
    logic [4:0]         frac_reg, frac_next;
    logic               term_reg, term_next;
    logic               fail_reg, fail_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic signed [67:0] t_reg, t_next;
    logic signed [36:0] p_reg, p_next;
    logic [63:0]        quo_reg, quo_next;
    logic [59:0]        rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               round_reg, round_next;
    logic               resneg_reg, resneg_next;
    logic signed [31:0] res_value_reg, res_value_next;
    logic               res_ok_reg, res_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_ok_reg, out_ok_next;

    // Shared adder/subtractor.
    logic signed [68:0] alu_a, alu_b, alu_y;
    logic               alu_sub;

    logic [3:0]         digit;
    logic               cfg_write;

    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign digit = 4'(char_reg - CH_ZERO);

    // Configuration register.
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SCALE);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SCALE) ? scale_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 32'sd1;
        end
        else if (cfg_write)
        begin
            scale_reg <= pwdata;
        end
    end

    // Port outputs.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign ok        = out_ok_reg;

    // Control and parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            sep_reg       <= 1'b0;
            frac_reg      <= '0;
            term_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            sep_reg       <= sep_next;
            frac_reg      <= frac_next;
            term_reg      <= term_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        last_reg      <= last_next;
        t_reg         <= t_next;
        p_reg         <= p_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        round_reg     <= round_next;
        resneg_reg    <= resneg_next;
        res_value_reg <= res_value_next;
        res_ok_reg    <= res_ok_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
    end

    // Sequencer: next state, shared adder operands and register updates.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        sep_next       = sep_reg;
        frac_next      = frac_reg;
        term_next      = term_reg;
        fail_next      = fail_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        resneg_next    = resneg_reg;
        res_value_next = res_value_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;

        // The result register empties when the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    char_next  = character;
                    last_next  = last;
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                // Digit: form acc*10 as (acc<<3)+(acc<<1) and digit*scale.
                alu_a  = {{2{acc_reg[63]}}, acc_reg, 3'b000};
                alu_b  = {{4{acc_reg[63]}}, acc_reg, 1'b0};
                t_next = alu_y[67:0];
                p_next = 37'($signed({1'b0, digit}) * scale_reg);
                state_next = last_reg ? ST_CLOSE : ST_IDLE;
                if (!term_reg && !fail_reg)
                begin
                    if (char_reg == CH_NUL)
                    begin
                        term_next = 1'b1;
                    end
                    else if (char_reg >= CH_ZERO && char_reg <= CH_NINE)
                    begin
                        started_next = 1'b1;
                        state_next   = ST_ADD;
                    end
                    else if (char_reg == CH_MINUS)
                    begin
                        if (started_reg || neg_reg)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            neg_next = 1'b1;
                        end
                    end
                    else if (char_reg == CH_DOT || char_reg == CH_COMMA)
                    begin
                        started_next = 1'b1;
                        if (sep_reg)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            sep_next = 1'b1;
                        end
                    end
                    else
                    begin
                        fail_next = 1'b1;
                    end
                end
            end

            ST_ADD:
            begin
                // Accumulate and check that both acc*10 and the sum fit in 64 bits.
                alu_a = {t_reg[67], t_reg};
                alu_b = {{32{p_reg[36]}}, p_reg};
                state_next = last_reg ? ST_CLOSE : ST_IDLE;
                if (!(t_reg[67:63] == '0 || t_reg[67:63] == '1)
                    || !(alu_y[68:63] == '0 || alu_y[68:63] == '1))
                begin
                    fail_next = 1'b1;
                end
                else
                begin
                    acc_next = alu_y[63:0];
                    if (sep_reg)
                    begin
                        if (frac_reg >= MAX_FRAC_DIGITS)
                        begin
                            fail_next = 1'b1;
                        end
                        else
                        begin
                            frac_next = frac_reg + 5'd1;
                        end
                    end
                end
            end

            ST_CLOSE:
            begin
                if (!fail_reg && started_reg && scale_reg != 32'sd0)
                begin
                    state_next = ST_NEG;
                end
                else
                begin
                    res_value_next = '0;
                    res_ok_next    = 1'b0;
                    state_next     = ST_EMIT;
                end
            end

            ST_NEG:
            begin
                // Magnitude of the accumulator.
                alu_b       = {{5{acc_reg[63]}}, acc_reg};
                alu_sub     = acc_reg[63];
                quo_next    = alu_y[63:0];
                resneg_next = acc_reg[63] != neg_reg;
                rem_next    = '0;
                cnt_next    = '0;
                round_next  = 1'b0;
                state_next  = (frac_reg == 5'd0) ? ST_FIX : ST_DIV;
            end

            ST_DIV:
            begin
                // One restoring division step per cycle by 10^k.
                alu_a   = {8'b0, rem_reg, quo_reg[63]};
                alu_b   = {5'b0, pow10(frac_reg)};
                alu_sub = 1'b1;
                if (!alu_y[68])
                begin
                    rem_next = alu_y[59:0];
                end
                else
                begin
                    rem_next = {rem_reg[58:0], quo_reg[63]};
                end
                quo_next = {quo_reg[62:0], ~alu_y[68]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                // Round half away from zero: 2r >= divisor with a nonzero remainder.
                alu_a      = {8'b0, rem_reg, 1'b0};
                alu_b      = {5'b0, pow10(frac_reg)};
                alu_sub    = 1'b1;
                round_next = !alu_y[68] && (rem_reg != '0);
                state_next = ST_FIX;
            end

            ST_FIX:
            begin
                alu_a      = {5'b0, quo_reg};
                alu_b      = {68'b0, round_reg};
                quo_next   = alu_y[63:0];
                state_next = ST_SIGN;
            end

            ST_SIGN:
            begin
                // Apply the sign and check the int32 range.
                alu_b       = {5'b0, quo_reg};
                alu_sub     = resneg_reg;
                res_ok_next = resneg_reg ? (quo_reg <= NEG_LIMIT) : (quo_reg <= POS_LIMIT);
                res_value_next = res_ok_next ? alu_y[31:0] : '0;
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                // Hand off once the result register is free, then start a new string.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_ok_next    = res_ok_reg;
                    acc_next       = '0;
                    neg_next       = 1'b0;
                    started_next   = 1'b0;
                    sep_next       = 1'b0;
                    frac_next      = '0;
                    term_next      = 1'b0;
                    fail_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/dssi_checker.sv
`default_nettype none

module dssi_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] value,
    input wire logic               ok
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(ok))
        else $error("result changed while stalled");

    // A failed parse reports zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> value == 32'sd0)
        else $error("failed result with nonzero value");

    // Every request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready directly after an accepted request");

    // A new result is loaded only from the busy sequencer.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind decimal_string_to_scaled_int_unit dssi_checker u_dssi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .ok        (ok)
);

`default_nettype wire

FILE: test/tb_decimal_string_to_scaled_int_unit.sv
`default_nettype none

module tb_decimal_string_to_scaled_int_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import dssi_pkg::*;

    // Register addresses on the configuration port.
    localparam logic [PADDR_W-1:0] ADDR_SCALE  = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = -I64_MAX - 1;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     SETTLE_CYCLES = 80;
    localparam int     SEGMENT_BYTES = 200;

    typedef logic [7:0] text_t[$];

    typedef struct {
        logic signed [31:0] value;
        logic               ok;
    } parse_result_t;

    // Tracks the parser state and holds the results that closed strings must produce.
    class scaled_parse_board;
        int            scale = 1;
        longint        acc;
        bit            negative;
        bit            started;
        bit            sep_seen;
        int            frac;
        bit            terminated;
        bit            failed;
        int            mismatches;
        parse_result_t parsed_results[$];

        function int pending();
            return parsed_results.size();
        endfunction

        // Applies one accepted request and queues the parse result when it closes the string.
        function void take_byte(logic [7:0] c, bit is_last);
            longint        prod;
            longint        grown;
            logic [63:0]   mag;
            logic [63:0]   div;
            logic [63:0]   quo;
            logic [63:0]   rem;
            bit            neg_res;
            parse_result_t res;
            if (!terminated && !failed) begin
                if (c == CH_NUL) begin
                    terminated = 1'b1;
                end
                else if (c >= CH_ZERO && c <= CH_NINE) begin
                    started = 1'b1;
                    prod = longint'(c - CH_ZERO) * longint'(scale);
                    if (acc > I64_MAX / 10 || acc < I64_MIN / 10) begin
                        failed = 1'b1;
                    end
                    else begin
                        grown = acc * 10;
                        if ((prod > 0 && grown > I64_MAX - prod) ||
                            (prod < 0 && grown < I64_MIN - prod)) begin
                            failed = 1'b1;
                        end
                        else begin
                            acc = grown + prod;
                            if (sep_seen) begin
                                if (frac >= int'(MAX_FRAC_DIGITS))
                                    failed = 1'b1;
                                else
                                    frac++;
                            end
                        end
                    end
                end
                else if (c == CH_MINUS) begin
                    if (started || negative)
                        failed = 1'b1;
                    else
                        negative = 1'b1;
                end
                else if (c == CH_DOT || c == CH_COMMA) begin
                    started = 1'b1;
                    if (sep_seen)
                        failed = 1'b1;
                    else
                        sep_seen = 1'b1;
                end
                else begin
                    failed = 1'b1;
                end
            end
            if (!is_last)
                return;

            // Divide by ten to the fraction digit count, rounding half away from zero.
            res.ok = !failed && started && scale != 0;
            res.value = '0;
            if (res.ok) begin
                neg_res = (acc < 0) != negative;
                mag = acc;
                if (acc < 0)
                    mag = 64'd0 - mag;
                div = 64'd1;
                for (int i = 0; i < frac && i < int'(MAX_FRAC_DIGITS); i++)
                    div = div * 64'd10;
                quo = mag / div;
                rem = mag % div;
                if (rem * 2 >= div && rem != 0)
                    quo++;
                if (neg_res) begin
                    if (quo > 64'h8000_0000)
                        res.ok = 1'b0;
                    else
                        res.value = 32'd0 - quo[31:0];
                end
                else begin
                    if (quo > 64'h7FFF_FFFF)
                        res.ok = 1'b0;
                    else
                        res.value = quo[31:0];
                end
            end
            parsed_results.push_back(res);
            acc = 0;
            negative = 1'b0;
            started = 1'b0;
            sep_seen = 1'b0;
            frac = 0;
            terminated = 1'b0;
            failed = 1'b0;
        endfunction

        // Compares one delivered result against the oldest queued one.
        function void check_parsed(logic signed [31:0] got_value, logic got_ok);
            parse_result_t want;
            if (parsed_results.size() == 0) begin
                $error("unexpected result: value %0d ok %0b", got_value, got_ok);
                mismatches++;
                return;
            end
            want = parsed_results.pop_front();
            if (got_ok !== want.ok) begin
                $error("ok: expected %0b, got %0b", want.ok, got_ok);
                mismatches++;
            end
            if (got_value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, got_value);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic [7:0]               character;
    logic                     last;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [31:0]       value;
    logic                     ok;

    scaled_parse_board board = new();

    int send_idle_pct;
    int recv_idle_pct;
    int send_quiet;
    int recv_quiet;
    int cycle_count;

    decimal_string_to_scaled_int_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .ok        (ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Decides one idle cycle; now and then a quiet stretch turns idling off for a while.
    function automatic bit take_gap(ref int quiet, input int pct);
        if (quiet > 0) begin
            quiet--;
            return 1'b0;
        end
        if ($urandom_range(49) == 0) begin
            quiet = $urandom_range(40, 10);
            return 1'b0;
        end
        return $urandom_range(99) < pct;
    endfunction

    // Receiver side: stalls at random according to the current idle rate.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= !take_gap(recv_quiet, recv_idle_pct);
        end
    end

    // Every accepted result is checked at the clock edge that moves it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_parsed(value, ok);
    end

    // Watchdog: a run that hangs ends as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_decimal_string_to_scaled_int_unit: FAIL");
        $finish;
    end

    // Sends one byte request and notes it once accepted.
    task automatic send_char(input logic [7:0] c, input bit is_last);
        @(negedge clk);
        while (take_gap(send_quiet, send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        last      <= is_last;
        do @(posedge clk); while (!in_ready);
        board.take_byte(c, is_last);
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
    endtask

    function automatic text_t text_of(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    // Holds the sender until every result is in, then lets a partial string's work finish.
    task automatic pause_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data when pready is high.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_SCALE)
            board.scale = $signed(data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_scale(input logic [31:0] data);
        pause_until_idle();
        write_reg(ADDR_SCALE, data);
    endtask

    // Mostly well-formed numbers with random content, the rest broken strings and noise.
    function automatic text_t make_text();
        text_t t;
        int    kind;
        int    n_int;
        int    n_frac;
        int    n_noise;
        kind = $urandom_range(99);
        if (kind < 72) begin
            if ($urandom_range(1))
                t.push_back(CH_MINUS);
            n_int = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(4);
            repeat (n_int) t.push_back(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(2) != 0) begin
                t.push_back($urandom_range(1) ? CH_DOT : CH_COMMA);
                n_frac = ($urandom_range(7) == 0) ? $urandom_range(20, 15) : $urandom_range(5);
                repeat (n_frac) t.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            // A NUL now and then, with trailing bytes that must be ignored.
            if ($urandom_range(9) == 0) begin
                t.push_back(CH_NUL);
                repeat ($urandom_range(3)) t.push_back(8'($urandom_range(255)));
            end
            if (t.size() == 0)
                t.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        else if (kind < 90) begin
            // Short mixes of the significant bytes: misplaced signs, doubled separators.
            n_noise = $urandom_range(6, 1);
            repeat (n_noise)
            begin
                case ($urandom_range(6))
                    0:       t.push_back(CH_MINUS);
                    1:       t.push_back(CH_DOT);
                    2:       t.push_back(CH_COMMA);
                    3:       t.push_back(CH_NUL);
                    4:       t.push_back(8'($urandom_range(255)));
                    default: t.push_back(8'(CH_ZERO + $urandom_range(9)));
                endcase
            end
        end
        else begin
            n_noise = $urandom_range(4, 1);
            repeat (n_noise) t.push_back(8'($urandom_range(255)));
        end
        return t;
    endfunction

    initial
    begin
        int          sent;
        text_t       t;
        logic [31:0] seg_scale;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        character = '0;
        last      = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 45;
        send_quiet = 0;
        recv_quiet = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings at the reset scale of one.
        send_text(text_of("0"));
        send_text(text_of("-9"));
        send_text(text_of("."));
        send_text(text_of("-,"));
        send_char(CH_NUL, 1'b1);
        send_char("7", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text(text_of("1-"));
        send_text(text_of(".."));
        send_text(text_of("x"));
        send_text(text_of("-"));
        send_text(text_of("2.5"));
        send_text(text_of("-0.45"));

        // A write to an unused address leaves the scale alone.
        pause_until_idle();
        write_reg(ADDR_UNUSED, 32'd77);
        send_text(text_of("3"));

        // The scale changes between two digits of one string.
        send_char("1", 1'b0);
        set_scale(32'd3);
        send_char("2", 1'b1);

        // Scale extremes reach both ends of the result range and just past them.
        set_scale(32'h7FFF_FFFF);
        send_text(text_of("1"));
        send_text(text_of("2"));
        set_scale(32'h8000_0000);
        send_text(text_of("1"));
        send_text(text_of("-1"));
        set_scale(32'd0);
        send_text(text_of("5"));

        // Random segments, each with its own scale; the idle pattern changes between groups of segments.
        for (int seg = 0; seg < 7; seg++)
        begin
            case (seg)
                0:       seg_scale = 32'd1;
                1:       seg_scale = 32'd1000;
                2:       seg_scale = 32'hFFFF_FFFF;
                3:       seg_scale = 32'h7FFF_FFFF;
                4:       seg_scale = 32'h8000_0000;
                5:       seg_scale = 32'd0;
                default: seg_scale = $urandom;
            endcase
            set_scale(seg_scale);
            if (seg < 3) begin
                send_idle_pct = 38;
                recv_idle_pct = 45;
            end
            else if (seg < 5) begin
                send_idle_pct = 45;
                recv_idle_pct = 38;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent = 0;
            while (sent < SEGMENT_BYTES)
            begin
                t = make_text();
                send_text(t);
                sent += t.size();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_decimal_string_to_scaled_int_unit: PASS");
        else
            $display("tb_decimal_string_to_scaled_int_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: decimal_string_to_scaled_int_unit.f
rtl/dssi_pkg.sv
rtl/decimal_string_to_scaled_int_unit.sv
rtl/dssi_checker.sv
test/tb_decimal_string_to_scaled_int_unit.sv
